FILE: sv/ps2sc_pkg.sv
// ----------------------------------------------------------------------------
// ps2sc_pkg
// Shared types, scan code constants and translation tables for the PS/2
// set-1 scan code decoder with its character FIFO.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

	localparam int FIFO_DEPTH = 256;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [7:0] NAV_BASE_RESET = 8'h80;

	localparam logic [7:0] SC_PREFIX   = 8'hE0;
	localparam logic [7:0] SC_LSHIFT   = 8'h2A;
	localparam logic [7:0] SC_RSHIFT   = 8'h36;
	localparam logic [7:0] SC_CTRL     = 8'h1D;
	localparam logic [7:0] SC_CAPS     = 8'h3A;
	localparam logic [7:0] SC_UP       = 8'h48;
	localparam logic [7:0] SC_DOWN     = 8'h50;
	localparam logic [7:0] SC_LEFT     = 8'h4B;
	localparam logic [7:0] SC_RIGHT    = 8'h4D;
	localparam logic [7:0] SC_HOME     = 8'h47;
	localparam logic [7:0] SC_END      = 8'h4F;
	localparam logic [7:0] SC_DELETE   = 8'h53;
	localparam logic [7:0] SC_PGUP     = 8'h49;
	localparam logic [7:0] SC_PGDN     = 8'h51;
	localparam logic [7:0] SC_INSERT   = 8'h52;
	localparam logic [7:0] REL_BIT     = 8'h80;
	localparam logic [7:0] LOW_MASK    = 8'h7F;

	localparam logic FUNC_SCAN = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] scan_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_valid;
		logic       dropped;
		logic [7:0] fifo_level;
	} out_item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_req_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [7:0] level;
	} fifo_stat_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] offset;
	} nav_t;

	// extended make code to navigation key offset
	function automatic nav_t nav_lookup(input logic [7:0] sc);
		nav_t n;
		n.hit = 1'b1;
		unique case (sc)
			SC_UP:     n.offset = 4'd0;
			SC_DOWN:   n.offset = 4'd1;
			SC_LEFT:   n.offset = 4'd2;
			SC_RIGHT:  n.offset = 4'd3;
			SC_HOME:   n.offset = 4'd4;
			SC_END:    n.offset = 4'd5;
			SC_DELETE: n.offset = 4'd6;
			SC_PGUP:   n.offset = 4'd7;
			SC_PGDN:   n.offset = 4'd8;
			SC_INSERT: n.offset = 4'd9;
			default: begin
				n.hit    = 1'b0;
				n.offset = 4'd0;
			end
		endcase
		return n;
	endfunction

	// normal and shifted translation tables, 0 for unmapped codes
	function automatic logic [7:0] scan_to_char(input logic [6:0] idx, input logic shift);
		logic [7:0] c;
		unique case (idx)
			7'd1:  c = 8'h1B;
			7'd2:  c = shift ? 8'h21 : 8'h31;
			7'd3:  c = shift ? 8'h40 : 8'h32;
			7'd4:  c = shift ? 8'h23 : 8'h33;
			7'd5:  c = shift ? 8'h24 : 8'h34;
			7'd6:  c = shift ? 8'h25 : 8'h35;
			7'd7:  c = shift ? 8'h5E : 8'h36;
			7'd8:  c = shift ? 8'h26 : 8'h37;
			7'd9:  c = shift ? 8'h2A : 8'h38;
			7'd10: c = shift ? 8'h28 : 8'h39;
			7'd11: c = shift ? 8'h29 : 8'h30;
			7'd12: c = shift ? 8'h5F : 8'h2D;
			7'd13: c = shift ? 8'h2B : 8'h3D;
			7'd14: c = 8'h08;
			7'd15: c = 8'h09;
			7'd16: c = shift ? 8'h51 : 8'h71;
			7'd17: c = shift ? 8'h57 : 8'h77;
			7'd18: c = shift ? 8'h45 : 8'h65;
			7'd19: c = shift ? 8'h52 : 8'h72;
			7'd20: c = shift ? 8'h54 : 8'h74;
			7'd21: c = shift ? 8'h59 : 8'h79;
			7'd22: c = shift ? 8'h55 : 8'h75;
			7'd23: c = shift ? 8'h49 : 8'h69;
			7'd24: c = shift ? 8'h4F : 8'h6F;
			7'd25: c = shift ? 8'h50 : 8'h70;
			7'd26: c = shift ? 8'h7B : 8'h5B;
			7'd27: c = shift ? 8'h7D : 8'h5D;
			7'd28: c = 8'h0A;
			7'd30: c = shift ? 8'h41 : 8'h61;
			7'd31: c = shift ? 8'h53 : 8'h73;
			7'd32: c = shift ? 8'h44 : 8'h64;
			7'd33: c = shift ? 8'h46 : 8'h66;
			7'd34: c = shift ? 8'h47 : 8'h67;
			7'd35: c = shift ? 8'h48 : 8'h68;
			7'd36: c = shift ? 8'h4A : 8'h6A;
			7'd37: c = shift ? 8'h4B : 8'h6B;
			7'd38: c = shift ? 8'h4C : 8'h6C;
			7'd39: c = shift ? 8'h3A : 8'h3B;
			7'd40: c = shift ? 8'h22 : 8'h27;
			7'd41: c = shift ? 8'h7E : 8'h60;
			7'd43: c = shift ? 8'h7C : 8'h5C;
			7'd44: c = shift ? 8'h5A : 8'h7A;
			7'd45: c = shift ? 8'h58 : 8'h78;
			7'd46: c = shift ? 8'h43 : 8'h63;
			7'd47: c = shift ? 8'h56 : 8'h76;
			7'd48: c = shift ? 8'h42 : 8'h62;
			7'd49: c = shift ? 8'h4E : 8'h6E;
			7'd50: c = shift ? 8'h4D : 8'h6D;
			7'd51: c = shift ? 8'h3C : 8'h2C;
			7'd52: c = shift ? 8'h3E : 8'h2E;
			7'd53: c = shift ? 8'h3F : 8'h2F;
			7'd55: c = 8'h2A;
			7'd57: c = 8'h20;
			7'd71: c = 8'h37;
			7'd72: c = 8'h38;
			7'd73: c = 8'h39;
			7'd74: c = 8'h2D;
			7'd75: c = 8'h34;
			7'd76: c = 8'h35;
			7'd77: c = 8'h36;
			7'd78: c = 8'h2B;
			7'd79: c = 8'h31;
			7'd80: c = 8'h32;
			7'd81: c = 8'h33;
			7'd82: c = 8'h30;
			7'd83: c = 8'h2E;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/ps2sc_decoder.sv
// ----------------------------------------------------------------------------
// ps2sc_decoder
// Modifier and prefix tracking plus scan byte to character translation.
// ----------------------------------------------------------------------------
module ps2sc_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] scan_byte,
	input  logic [7:0] nav_base,
	output logic [7:0] char_out
);
	import ps2sc_pkg::*;

	logic shift_q, caps_q, ctrl_q, prefix_q;
	logic shift_d, caps_d, ctrl_d, prefix_d;
	logic [7:0] low;
	logic [7:0] tc;
	logic       is_letter;
	nav_t       nav;

	assign low = scan_byte & LOW_MASK;
	assign nav = nav_lookup(scan_byte);

	always_comb begin
		shift_d  = shift_q;
		caps_d   = caps_q;
		ctrl_d   = ctrl_q;
		prefix_d = prefix_q;
		char_out = 8'h00;
		tc        = scan_to_char(scan_byte[6:0], shift_q);
		is_letter = 1'b0;
		if (scan_byte == SC_PREFIX) begin
			prefix_d = 1'b1;
		end else if (prefix_q) begin
			prefix_d = 1'b0;
			// extended release is ignored
			if ((scan_byte & REL_BIT) == 8'h00 && nav.hit) begin
				char_out = nav_base + {4'h0, nav.offset};
			end
		end else if ((scan_byte & REL_BIT) != 8'h00) begin
			if (low == SC_LSHIFT || low == SC_RSHIFT) begin
				shift_d = 1'b0;
			end
			if (low == SC_CTRL) begin
				ctrl_d = 1'b0;
			end
		end else if (scan_byte == SC_LSHIFT || scan_byte == SC_RSHIFT) begin
			shift_d = 1'b1;
		end else if (scan_byte == SC_CAPS) begin
			caps_d = ~caps_q;
		end else if (scan_byte == SC_CTRL) begin
			ctrl_d = 1'b1;
		end else begin
			is_letter = (tc >= 8'h61 && tc <= 8'h7A) || (tc >= 8'h41 && tc <= 8'h5A);
			// caps flips bit 5 of letters only
			if (caps_q && is_letter) begin
				tc = tc ^ 8'h20;
			end
			if (ctrl_q && is_letter) begin
				tc = tc & 8'h1F;
			end
			char_out = tc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			caps_q   <= 1'b0;
			ctrl_q   <= 1'b0;
			prefix_q <= 1'b0;
		end else if (step) begin
			shift_q  <= shift_d;
			caps_q   <= caps_d;
			ctrl_q   <= ctrl_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

FILE: sv/ps2sc_fifo.sv
// ----------------------------------------------------------------------------
// ps2sc_fifo
// Ring buffer of characters holding up to FIFO_DEPTH-1 entries, with a
// registered read port and a level count.
// ----------------------------------------------------------------------------
module ps2sc_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ps2sc_pkg::fifo_req_t   req,
	input  logic [7:0]             wdata,
	output ps2sc_pkg::fifo_stat_t  stat,
	output logic [7:0]             rdata
);
	import ps2sc_pkg::*;

	logic [7:0]         mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q, count_q;
	logic [FIFO_AW-1:0] count_d;
	logic [FIFO_AW+7:0] lvl_wide;
	logic               push_ok, pop_ok;

	assign stat.full  = (count_q == FIFO_AW'(FIFO_DEPTH - 1));
	assign stat.empty = (count_q == '0);
	assign push_ok    = req.push && !stat.full;
	assign pop_ok     = req.pop && !stat.empty;

	always_comb begin
		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + 1'b1;
		end else if (pop_ok) begin
			count_d = count_q - 1'b1;
		end
	end

	// level after this item, saturated to 8 bits
	assign lvl_wide   = (FIFO_AW + 8)'(count_d);
	assign stat.level = (lvl_wide > (FIFO_AW + 8)'(255)) ? 8'hFF : lvl_wide[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (push_ok) begin
				wptr_q <= (wptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop_ok) begin
				rptr_q <= (rptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wptr_q] <= wdata;
		end
		if (pop_ok) begin
			rdata <= mem[rptr_q];
		end
	end

endmodule

FILE: sv/ps2_scancode_to_ascii_fifo_top.sv
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_fifo_top
// PS/2 set-1 scan code to character decoder feeding a character FIFO.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_item  (func, scan_byte)
//   out      output     out_valid/out_stall out_item (out_char, out_valid,
//                                                     dropped, fifo_level)
//   cfg      input      cfg_we             cfg_wdata (nav_key_base)
//
// One item per cycle sustained while out_stall is low; a result is presented
// once its item has passed the input register, then decode and FIFO update
// into the result register, which also holds the memory read data for a pop.
// Reset clears modifiers, prefix, FIFO pointers and count; nav_key_base
// resets to 128. The ring contents are not cleared.
// out_stall holds the result register; the input register keeps taking an
// item until it is also full, then in_stall rises.
// ----------------------------------------------------------------------------
module ps2_scancode_to_ascii_fifo_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  ps2sc_pkg::in_item_t    in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ps2sc_pkg::out_item_t   out_item,
	input  logic                   cfg_we,
	input  logic [7:0]             cfg_wdata
);
	import ps2sc_pkg::*;

	logic       s1_valid_q, s2_valid_q;
	in_item_t   item_s1;
	logic [7:0] nav_base_q;
	logic       adv, step;
	logic [7:0] dec_char;
	logic [7:0] rdata;
	fifo_req_t  req;
	fifo_stat_t stat;

	logic [7:0] char_s2;
	logic       sel_rd_s2, valid_s2, dropped_s2;
	logic [7:0] level_s2;

	assign adv      = !s2_valid_q || !out_stall;
	assign in_stall = s1_valid_q && !adv;
	assign step     = s1_valid_q && adv;

	assign req.push = step && (item_s1.func == FUNC_SCAN) && (dec_char != 8'h00);
	assign req.pop  = step && (item_s1.func == FUNC_POP);

	ps2sc_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step && (item_s1.func == FUNC_SCAN)),
		.scan_byte (item_s1.scan_byte),
		.nav_base  (nav_base_q),
		.char_out  (dec_char)
	);

	ps2sc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.wdata  (dec_char),
		.stat   (stat),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			nav_base_q <= NAV_BASE_RESET;
		end else begin
			if (cfg_we) begin
				nav_base_q <= cfg_wdata;
			end
			if (!in_stall) begin
				s1_valid_q <= in_valid;
			end
			if (adv) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
		if (step) begin
			char_s2    <= (item_s1.func == FUNC_SCAN) ? dec_char : 8'h00;
			sel_rd_s2  <= req.pop && !stat.empty;
			valid_s2   <= (req.push && !stat.full) || (req.pop && !stat.empty);
			dropped_s2 <= req.push && stat.full;
			level_s2   <= stat.level;
		end
	end

	assign out_valid           = s2_valid_q;
	assign out_item.out_char   = sel_rd_s2 ? rdata : char_s2;
	assign out_item.out_valid  = valid_s2;
	assign out_item.dropped    = dropped_s2;
	assign out_item.fifo_level = level_s2;

endmodule

FILE: dv/ps2_scancode_to_ascii_fifo_top_test.sv
// ----------------------------------------------------------------------------
// ps2_scancode_to_ascii_fifo_top_test
// Self-checking bench for the set-1 scan code decoder and its character FIFO.
// A short table of directed keys runs first: modifiers, caps lock, ctrl,
// prefixed navigation keys, releases and pops on an empty FIFO. Random key
// streams follow under several navigation bases, including a run that fills
// the FIFO past full and one that drains it past empty. Every result is
// compared in order against the bench's predictor or, for the first directed
// rows, fixed ones, with random input gaps and output stalls until the last run.
// ----------------------------------------------------------------------------
module ps2_scancode_to_ascii_fifo_top_test;
	import ps2sc_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	// unshifted characters for make codes 0..83
	localparam logic [0:83][7:0] PLAIN_MAP = {
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
		8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
		8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
		8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32, 8'h33, 8'h30, 8'h2E
	};

	// shifted characters for make codes 0..53, the keypad is the same either way
	localparam logic [0:53][7:0] SHIFT_MAP = {
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
		8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
		8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F
	};

	localparam logic [0:9][7:0] NAV_CODES = {
		SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME,
		SC_END, SC_DELETE, SC_PGUP, SC_PGDN, SC_INSERT
	};
	localparam logic [0:3][7:0] MOD_CODES = {SC_LSHIFT, SC_RSHIFT, SC_CTRL, SC_CAPS};

	typedef struct packed {
		in_item_t  stim;
		logic      typed;
		out_item_t fixed;
	} key_row_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;
	logic      cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;

	// predictor state
	logic [7:0] ring_mirror [FIFO_DEPTH];
	int         ring_wr = 0;
	int         ring_rd = 0;
	logic       kb_shift = 1'b0;
	logic       kb_caps = 1'b0;
	logic       kb_ctrl = 1'b0;
	logic       kb_prefix = 1'b0;
	logic [7:0] nav_base = NAV_BASE_RESET;

	out_item_t  decoded_due [$];
	out_item_t  oldest;
	int         errors = 0;
	int         quiet_cycles = 0;
	int         stall_left = 0;
	bit         bursty = 1'b1;

	key_row_t directed_rows [25] = '{
		'{'{FUNC_POP,  8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00}},
		'{'{FUNC_SCAN, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 8'h00}},
		'{'{FUNC_SCAN, 8'h1E}, 1'b1, '{8'h61, 1'b1, 1'b0, 8'h01}},
		'{'{FUNC_SCAN, SC_LSHIFT}, 1'b0, '0},
		'{'{FUNC_SCAN, 8'h1E}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_LSHIFT | REL_BIT}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_CAPS}, 1'b0, '0},
		'{'{FUNC_SCAN, 8'h10}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_RSHIFT}, 1'b0, '0},
		'{'{FUNC_SCAN, 8'h1E}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_RSHIFT | REL_BIT}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_CAPS}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_CTRL}, 1'b0, '0},
		'{'{FUNC_SCAN, 8'h2E}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_CTRL | REL_BIT}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_PREFIX}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_PREFIX}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_UP}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_PREFIX}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_UP | REL_BIT}, 1'b0, '0},
		'{'{FUNC_SCAN, SC_PREFIX}, 1'b0, '0},
		'{'{FUNC_SCAN, 8'h1E}, 1'b0, '0},
		'{'{FUNC_SCAN, 8'hFF}, 1'b0, '0},
		'{'{FUNC_SCAN, 8'h7F}, 1'b0, '0},
		'{'{FUNC_POP,  8'hFF}, 1'b0, '0}
	};

	ps2_scancode_to_ascii_fifo_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// character for one scan byte, updating the keyboard state
	function automatic logic [7:0] key_char(input logic [7:0] sc);
		logic [7:0] c;
		int         k;
		c = 8'h00;
		k = -1;
		if (sc == SC_PREFIX) begin
			kb_prefix = 1'b1;
		end else if (kb_prefix) begin
			kb_prefix = 1'b0;
			if ((sc & REL_BIT) == 8'h00) begin
				for (int i = 0; i < 10; i++)
					if (NAV_CODES[4'(i)] == sc) k = i;
				if (k >= 0) c = nav_base + 8'(k);
			end
		end else if ((sc & REL_BIT) != 8'h00) begin
			if ((sc & LOW_MASK) == SC_LSHIFT || (sc & LOW_MASK) == SC_RSHIFT) kb_shift = 1'b0;
			if ((sc & LOW_MASK) == SC_CTRL) kb_ctrl = 1'b0;
		end else if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
			kb_shift = 1'b1;
		end else if (sc == SC_CAPS) begin
			kb_caps = ~kb_caps;
		end else if (sc == SC_CTRL) begin
			kb_ctrl = 1'b1;
		end else if (sc < 8'd84) begin
			c = (kb_shift && sc < 8'd54) ? SHIFT_MAP[sc[5:0]] : PLAIN_MAP[sc[6:0]];
			// caps lock flips the case of letters only
			if (kb_caps && ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)))
				c = c ^ 8'h20;
			if (kb_ctrl && ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)))
				c = c & 8'h1F;
		end
		return c;
	endfunction

	function automatic out_item_t decode_step(input in_item_t it);
		out_item_t r;
		int        nxt;
		int        lvl;
		r = '0;
		if (it.func == FUNC_SCAN) begin
			r.out_char = key_char(it.scan_byte);
			if (r.out_char != 8'h00) begin
				nxt = (ring_wr + 1) % FIFO_DEPTH;
				if (nxt != ring_rd) begin
					ring_mirror[FIFO_AW'(ring_wr)] = r.out_char;
					ring_wr = nxt;
					r.out_valid = 1'b1;
				end else begin
					r.dropped = 1'b1;
				end
			end
		end else if (ring_rd != ring_wr) begin
			r.out_char = ring_mirror[FIFO_AW'(ring_rd)];
			ring_rd = (ring_rd + 1) % FIFO_DEPTH;
			r.out_valid = 1'b1;
		end
		lvl = (ring_wr + FIFO_DEPTH - ring_rd) % FIFO_DEPTH;
		r.fifo_level = lvl > 255 ? 8'd255 : 8'(lvl);
		return r;
	endfunction

	task automatic send_key(input in_item_t it, input bit typed = 1'b0,
			input out_item_t fixed = '0);
		out_item_t predicted;
		if (bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = decode_step(it);
		decoded_due.push_back(typed ? fixed : predicted);
	endtask

	// mostly plausible key traffic: makes, modifiers, releases, prefixed keys
	task automatic random_keys(input int count, input int pop_pct);
		int sent;
		int pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < pop_pct) begin
				send_key(in_item_t'{FUNC_POP, 8'($urandom)});
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 62) begin
					send_key(in_item_t'{FUNC_SCAN, 8'($urandom_range(1, 83))});
				end else if (pick < 68) begin
					send_key(in_item_t'{FUNC_SCAN, MOD_CODES[2'($urandom_range(0, 3))]});
				end else if (pick < 74) begin
					send_key(in_item_t'{FUNC_SCAN,
						MOD_CODES[2'($urandom_range(0, 2))] | REL_BIT});
				end else if (pick < 78) begin
					send_key(in_item_t'{FUNC_SCAN, 8'($urandom) | REL_BIT});
				end else if (pick < 94) begin
					send_key(in_item_t'{FUNC_SCAN, SC_PREFIX});
					sent++;
					if (pick < 90)
						send_key(in_item_t'{FUNC_SCAN, NAV_CODES[4'($urandom_range(0, 9))]});
					else
						send_key(in_item_t'{FUNC_SCAN, 8'($urandom)});
				end else begin
					send_key(in_item_t'{FUNC_SCAN, 8'($urandom)});
				end
			end
			sent++;
		end
	endtask

	// write the base only once every result is back and the pipe is empty
	task automatic set_nav_base(input logic [7:0] base);
		in_valid <= 1'b0;
		while (decoded_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wdata <= base;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		nav_base = base;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, got %h", $time, out_item);
			end else begin
				oldest = decoded_due.pop_front();
				if (out_item.out_char !== oldest.out_char
						|| out_item.out_valid !== oldest.out_valid
						|| out_item.dropped !== oldest.dropped
						|| out_item.fifo_level !== oldest.fifo_level) begin
					errors++;
					$display("%0t: expected %h/%b/%b/%0d got %h/%b/%b/%0d",
						$time, oldest.out_char, oldest.out_valid, oldest.dropped,
						oldest.fifo_level, out_item.out_char, out_item.out_valid,
						out_item.dropped, out_item.fifo_level);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (bursty && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 18);
		out_stall <= (stall_left > 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_key(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].fixed);

		// base 0 makes the up arrow a zero code that is never stored
		set_nav_base(8'd0);
		send_key(in_item_t'{FUNC_SCAN, SC_PREFIX});
		send_key(in_item_t'{FUNC_SCAN, SC_UP});
		random_keys(120, 30);

		set_nav_base(8'd246);
		random_keys(120, 30);

		// overfill with letters, then drain well past empty
		set_nav_base(8'($urandom_range(0, 246)));
		repeat (260) send_key(in_item_t'{FUNC_SCAN, 8'($urandom_range(16, 25))});
		random_keys(400, 90);

		bursty = 1'b0;
		set_nav_base(8'($urandom_range(0, 246)));
		random_keys(150, 45);

		in_valid <= 1'b0;
		while (decoded_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
